// ----- rtl/core/avd_pkg.sv -----
// Shared types, constants and lookup functions for the ADPCM voice decoder.
// Used by every module of the decoder; depends on nothing else.
`default_nettype none
package avd_pkg;

  localparam int STEP_ENTRIES = 49;
  localparam int STEP_MAX     = STEP_ENTRIES - 1;
  localparam int STEP_W       = $clog2(STEP_ENTRIES);
  localparam int STEP_VAL_W   = 11;
  localparam int LEVEL_W      = 12;
  localparam int LEVEL_MAX    = 2047;
  localparam int LEVEL_MIN    = -2048;
  localparam int SAMPLE_W     = 16;
  localparam int SAMPLE_MAX   = 32767;
  localparam int SAMPLE_MIN_MAG = 32768;
  localparam int VOL_W        = 8;
  localparam int CODE_W       = 4;
  localparam int VALUE_W      = 4;
  localparam int MODE_W       = 2;
  localparam int PSEL_W       = 2;
  localparam int CMD_DEPTH    = 4;
  localparam int CMD_AW       = $clog2(CMD_DEPTH);
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 8;
  localparam int PROD_W       = 20;
  localparam int QUOT_W       = 17;

  // Reciprocal of 100 for truncating division of values below 2^23.
  localparam logic [23:0] RECIP_100   = 24'd10737419;
  localparam int          RECIP_SHIFT = 30;

  localparam logic [MODE_W-1:0] MODE_DATA      = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RESET_PIN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLOCK_PIN = 2'd2;
  localparam logic [MODE_W-1:0] MODE_TICK      = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_BIT_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESCALER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME    = 2'd2;

  localparam logic [PSEL_W-1:0] PSEL_EXTERNAL = 2'd3;

  localparam logic              BIT_WIDTH_RESET = 1'b1;
  localparam logic [PSEL_W-1:0] PSEL_RESET      = 2'd3;
  localparam logic [VOL_W-1:0]  VOLUME_RESET    = 8'd100;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              rst;
  } cmd_t;

  function automatic logic [STEP_VAL_W-1:0] step_size(input logic [STEP_W-1:0] idx);
    logic [STEP_VAL_W-1:0] v;
    case (idx)
      6'd0:  v = 11'd16;   6'd1:  v = 11'd17;   6'd2:  v = 11'd19;
      6'd3:  v = 11'd21;   6'd4:  v = 11'd23;   6'd5:  v = 11'd25;
      6'd6:  v = 11'd28;   6'd7:  v = 11'd31;   6'd8:  v = 11'd34;
      6'd9:  v = 11'd37;   6'd10: v = 11'd41;   6'd11: v = 11'd45;
      6'd12: v = 11'd50;   6'd13: v = 11'd55;   6'd14: v = 11'd60;
      6'd15: v = 11'd66;   6'd16: v = 11'd73;   6'd17: v = 11'd80;
      6'd18: v = 11'd88;   6'd19: v = 11'd97;   6'd20: v = 11'd107;
      6'd21: v = 11'd118;  6'd22: v = 11'd130;  6'd23: v = 11'd143;
      6'd24: v = 11'd157;  6'd25: v = 11'd173;  6'd26: v = 11'd190;
      6'd27: v = 11'd209;  6'd28: v = 11'd230;  6'd29: v = 11'd253;
      6'd30: v = 11'd279;  6'd31: v = 11'd307;  6'd32: v = 11'd337;
      6'd33: v = 11'd371;  6'd34: v = 11'd408;  6'd35: v = 11'd449;
      6'd36: v = 11'd494;  6'd37: v = 11'd544;  6'd38: v = 11'd598;
      6'd39: v = 11'd658;  6'd40: v = 11'd724;  6'd41: v = 11'd796;
      6'd42: v = 11'd876;  6'd43: v = 11'd963;  6'd44: v = 11'd1060;
      6'd45: v = 11'd1166; 6'd46: v = 11'd1282; 6'd47: v = 11'd1411;
      default: v = 11'd1552;
    endcase
    return v;
  endfunction

  function automatic logic signed [4:0] index_adjust(input logic [2:0] c);
    logic signed [4:0] a;
    case (c)
      3'd4:    a = 5'sd2;
      3'd5:    a = 5'sd4;
      3'd6:    a = 5'sd6;
      3'd7:    a = 5'sd8;
      default: a = -5'sd1;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/adpcm_voice_decoder.sv -----
// Top level of the ADPCM voice decoder: configuration registers, front end,
// command queue and decode pipeline. Depends on avd_pkg, avd_front,
// avd_cmd_fifo and avd_back.
//
//   Channel   Ports                                   Transfer when
//   input     in_push, in_full, in_mode, in_value     in_push && !in_full
//   result    out_pop, out_empty, out_sample, ...     out_pop && !out_empty
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid && cfg_ready
//
// One event is accepted per clock while the queue is not full. A command passes the
// four-entry queue and then the pipeline stages to the result ports, and results
// leave at one per clock while out_pop stays high.
// The rate is set by the level and step update in the first pipeline stage.
// Reset is synchronous and needs no clearing pass.
// A held result stalls the pipeline; events continue until the queue fills.
`default_nettype none
module adpcm_voice_decoder (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_push,
  output logic                                     in_full,
  input  wire logic [avd_pkg::MODE_W-1:0]          in_mode,
  input  wire logic [avd_pkg::VALUE_W-1:0]         in_value,
  output logic                                     out_empty,
  input  wire logic                                out_pop,
  output logic signed [avd_pkg::SAMPLE_W-1:0]      out_sample,
  output logic signed [avd_pkg::LEVEL_W-1:0]       out_level,
  output logic                                     out_changed,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [avd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [avd_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic                         bit_width_r;
  logic [avd_pkg::PSEL_W-1:0]   psel_r;
  logic [avd_pkg::VOL_W-1:0]    volume_r;

  logic                         cmd_push;
  avd_pkg::cmd_t                cmd_in;
  logic                         cmd_full;
  logic                         cmd_pop;
  avd_pkg::cmd_t                cmd_out;
  logic                         cmd_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_width_r <= avd_pkg::BIT_WIDTH_RESET;
      psel_r      <= avd_pkg::PSEL_RESET;
      volume_r    <= avd_pkg::VOLUME_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        avd_pkg::CFG_BIT_WIDTH: bit_width_r <= cfg_data[0];
        avd_pkg::CFG_PRESCALER: psel_r      <= cfg_data[avd_pkg::PSEL_W-1:0];
        avd_pkg::CFG_VOLUME:    volume_r    <= cfg_data[avd_pkg::VOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  avd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_mode       (in_mode),
    .in_value      (in_value),
    .bit_width_sel (bit_width_r),
    .prescaler_sel (psel_r),
    .cmd_push      (cmd_push),
    .cmd           (cmd_in),
    .cmd_full      (cmd_full)
  );

  avd_cmd_fifo u_cmd_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cmd_push),
    .cmd_in  (cmd_in),
    .full    (cmd_full),
    .pop     (cmd_pop),
    .cmd_out (cmd_out),
    .empty   (cmd_empty)
  );

  avd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd_out),
    .cmd_empty   (cmd_empty),
    .cmd_pop     (cmd_pop),
    .volume      (volume_r),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_sample  (out_sample),
    .out_level   (out_level),
    .out_changed (out_changed)
  );

endmodule
`default_nettype wire

// ----- rtl/core/avd_front.sv -----
// Front end: accepts pin events, holds the code latch and pin levels, and
// issues decode commands. Depends on avd_pkg.
`default_nettype none
module avd_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire logic [avd_pkg::MODE_W-1:0]    in_mode,
  input  wire logic [avd_pkg::VALUE_W-1:0]   in_value,
  input  wire logic                          bit_width_sel,
  input  wire logic [avd_pkg::PSEL_W-1:0]    prescaler_sel,
  output logic                               cmd_push,
  output avd_pkg::cmd_t                      cmd,
  input  wire logic                          cmd_full
);

  logic [avd_pkg::CODE_W-1:0] code_r, code_nxt;
  logic                       clk_pin_r, clk_pin_nxt;
  logic                       rst_pin_r, rst_pin_nxt;
  logic                       accept;
  logic                       issue;

  assign in_full = cmd_full;
  assign accept  = in_push && !cmd_full;

  always_comb begin
    code_nxt    = code_r;
    clk_pin_nxt = clk_pin_r;
    rst_pin_nxt = rst_pin_r;
    issue       = 1'b0;
    if (accept) begin
      case (in_mode)
        avd_pkg::MODE_DATA: begin
          if (bit_width_sel) begin
            code_nxt = in_value;
          end else begin
            code_nxt = {in_value[2:0], 1'b0};
          end
        end
        avd_pkg::MODE_RESET_PIN: begin
          rst_pin_nxt = in_value[0];
        end
        avd_pkg::MODE_CLOCK_PIN: begin
          if (prescaler_sel == avd_pkg::PSEL_EXTERNAL && in_value[0] != clk_pin_r) begin
            clk_pin_nxt = in_value[0];
            issue       = !in_value[0];
          end
        end
        default: begin
          issue = (prescaler_sel != avd_pkg::PSEL_EXTERNAL);
        end
      endcase
    end
  end

  assign cmd_push = issue;
  assign cmd.code = code_r;
  assign cmd.rst  = rst_pin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r    <= '0;
      clk_pin_r <= 1'b0;
      rst_pin_r <= 1'b0;
    end else begin
      code_r    <= code_nxt;
      clk_pin_r <= clk_pin_nxt;
      rst_pin_r <= rst_pin_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/avd_cmd_fifo.sv -----
// Short command queue between the front end and the decode pipeline.
// Depends on avd_pkg for the command type and depth.
`default_nettype none
module avd_cmd_fifo (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire avd_pkg::cmd_t cmd_in,
  output logic        full,
  input  wire logic   pop,
  output avd_pkg::cmd_t cmd_out,
  output logic        empty
);

  avd_pkg::cmd_t              mem_r [avd_pkg::CMD_DEPTH];
  logic [avd_pkg::CMD_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [avd_pkg::CMD_AW:0]   count_r;
  logic                       do_push, do_pop;

  assign full    = (count_r == (avd_pkg::CMD_AW+1)'(avd_pkg::CMD_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign cmd_out = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/avd_back.sv -----
// Decode pipeline: level and step update, gain multiply, divide by one hundred
// and saturation over four stages. Depends on avd_pkg.
`default_nettype none
module avd_back (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire avd_pkg::cmd_t                        cmd,
  input  wire logic                                 cmd_empty,
  output logic                                      cmd_pop,
  input  wire logic [avd_pkg::VOL_W-1:0]            volume,
  output logic                                      out_empty,
  input  wire logic                                 out_pop,
  output logic signed [avd_pkg::SAMPLE_W-1:0]       out_sample,
  output logic signed [avd_pkg::LEVEL_W-1:0]        out_level,
  output logic                                      out_changed
);

  logic signed [avd_pkg::LEVEL_W-1:0] level_r, level_nxt;
  logic [avd_pkg::STEP_W-1:0]         step_r, step_nxt;

  logic                               en;
  logic [avd_pkg::STEP_VAL_W-1:0]     sv;
  logic [avd_pkg::LEVEL_W-1:0]        mag;
  logic signed [13:0]                 raw;
  logic signed [6:0]                  idx_raw;

  logic                               s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  logic signed [avd_pkg::LEVEL_W-1:0] s1_level_r, s2_level_r, s3_level_r;
  logic                               s1_chg_r, s2_chg_r, s3_chg_r;
  logic                               s2_neg_r, s3_neg_r;
  logic [avd_pkg::LEVEL_W-1:0]        s1_abs;
  logic [avd_pkg::PROD_W-1:0]         s2_mag_r;
  logic [47:0]                        s2_prod;
  logic [avd_pkg::QUOT_W-1:0]         s3_quot_r;
  logic signed [avd_pkg::SAMPLE_W-1:0] sample_nxt;
  logic signed [avd_pkg::SAMPLE_W-1:0] s4_sample_r;
  logic signed [avd_pkg::LEVEL_W-1:0]  s4_level_r;
  logic                                s4_chg_r;

  assign en      = !s4_vld_r || out_pop;
  assign cmd_pop = en && !cmd_empty;

  always_comb begin
    sv  = avd_pkg::step_size(step_r);
    mag = avd_pkg::LEVEL_W'(sv >> 3);
    if (cmd.code[2]) begin
      mag = mag + avd_pkg::LEVEL_W'(sv);
    end
    if (cmd.code[1]) begin
      mag = mag + avd_pkg::LEVEL_W'(sv >> 1);
    end
    if (cmd.code[0]) begin
      mag = mag + avd_pkg::LEVEL_W'(sv >> 2);
    end
    if (cmd.code[3]) begin
      raw = 14'(level_r) - $signed({2'b00, mag});
    end else begin
      raw = 14'(level_r) + $signed({2'b00, mag});
    end
    idx_raw = $signed({1'b0, step_r}) + 7'(avd_pkg::index_adjust(cmd.code[2:0]));
    if (raw > avd_pkg::LEVEL_MAX) begin
      level_nxt = avd_pkg::LEVEL_W'(avd_pkg::LEVEL_MAX);
    end else if (raw < avd_pkg::LEVEL_MIN) begin
      level_nxt = avd_pkg::LEVEL_W'(avd_pkg::LEVEL_MIN);
    end else begin
      level_nxt = raw[avd_pkg::LEVEL_W-1:0];
    end
    if (idx_raw > avd_pkg::STEP_MAX) begin
      step_nxt = avd_pkg::STEP_W'(avd_pkg::STEP_MAX);
    end else if (idx_raw < 0) begin
      step_nxt = '0;
    end else begin
      step_nxt = idx_raw[avd_pkg::STEP_W-1:0];
    end
    if (cmd.rst) begin
      level_nxt = '0;
      step_nxt  = '0;
    end
  end

  assign s1_abs  = s1_level_r[avd_pkg::LEVEL_W-1] ? (~s1_level_r + 1'b1) : s1_level_r;
  assign s2_prod = 48'({s2_mag_r, 4'b0000}) * 48'(avd_pkg::RECIP_100);

  always_comb begin
    if (!s3_neg_r) begin
      if (s3_quot_r > avd_pkg::QUOT_W'(avd_pkg::SAMPLE_MAX)) begin
        sample_nxt = avd_pkg::SAMPLE_W'(avd_pkg::SAMPLE_MAX);
      end else begin
        sample_nxt = s3_quot_r[avd_pkg::SAMPLE_W-1:0];
      end
    end else begin
      if (s3_quot_r > avd_pkg::QUOT_W'(avd_pkg::SAMPLE_MIN_MAG)) begin
        sample_nxt = {1'b1, {(avd_pkg::SAMPLE_W-1){1'b0}}};
      end else begin
        sample_nxt = ~s3_quot_r[avd_pkg::SAMPLE_W-1:0] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r  <= '0;
      step_r   <= '0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      if (cmd_pop) begin
        level_r <= level_nxt;
        step_r  <= step_nxt;
      end
      if (en) begin
        s1_vld_r <= cmd_pop;
        s2_vld_r <= s1_vld_r;
        s3_vld_r <= s2_vld_r;
        s4_vld_r <= s3_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_level_r  <= level_nxt;
      s1_chg_r    <= (level_nxt != level_r);
      s2_level_r  <= s1_level_r;
      s2_chg_r    <= s1_chg_r;
      s2_neg_r    <= s1_level_r[avd_pkg::LEVEL_W-1];
      s2_mag_r    <= avd_pkg::PROD_W'(s1_abs * volume);
      s3_level_r  <= s2_level_r;
      s3_chg_r    <= s2_chg_r;
      s3_neg_r    <= s2_neg_r;
      s3_quot_r   <= s2_prod[avd_pkg::RECIP_SHIFT +: avd_pkg::QUOT_W];
      s4_level_r  <= s3_level_r;
      s4_chg_r    <= s3_chg_r;
      s4_sample_r <= sample_nxt;
    end
  end

  assign out_empty   = !s4_vld_r;
  assign out_sample  = s4_sample_r;
  assign out_level   = s4_level_r;
  assign out_changed = s4_chg_r;

`ifndef SYNTHESIS
  a_reset_decode_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop && cmd.rst |=> level_r == '0 && step_r == '0 && s1_level_r == '0)
    else $error("Decode under held reset did not clear level and step.");

  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= avd_pkg::STEP_W'(avd_pkg::STEP_MAX))
    else $error("Step index beyond the step table.");

  a_pop_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |=> s1_vld_r && s1_level_r == level_r)
    else $error("Decoded command did not enter the first stage.");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(level_r) && $stable(step_r) && $stable(s1_level_r))
    else $error("Decode state moved while the pipeline was stalled.");
`endif

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the ADPCM voice decoder. It drives pin events,
// predicts every decode result and checks the transfers on the result side.
// Depends on avd_pkg and adpcm_voice_decoder.
`default_nettype none
module tb;
  import avd_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int SETTLE       = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [PSEL_W-1:0] PSEL_DIV96 = 2'd0;
  localparam logic [PSEL_W-1:0] PSEL_DIV48 = 2'd1;
  localparam logic [PSEL_W-1:0] PSEL_DIV64 = 2'd2;

  localparam int STEP_TABLE [STEP_ENTRIES] = '{
    16, 17, 19, 21, 23, 25, 28, 31, 34, 37, 41, 45, 50, 55, 60, 66, 73,
    80, 88, 97, 107, 118, 130, 143, 157, 173, 190, 209, 230, 253, 279,
    307, 337, 371, 408, 449, 494, 544, 598, 658, 724, 796, 876, 963,
    1060, 1166, 1282, 1411, 1552
  };
  localparam int ADJUST_TABLE [8] = '{-1, -1, -1, -1, 2, 4, 6, 8};

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [VALUE_W-1:0] value;
  } pin_event_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [LEVEL_W-1:0]  level;
    logic                       changed;
  } pcm_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_push = 1'b0;
  logic                       in_full;
  logic [MODE_W-1:0]          in_mode = '0;
  logic [VALUE_W-1:0]         in_value = '0;
  logic                       out_empty;
  logic                       out_pop = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic signed [LEVEL_W-1:0]  out_level;
  logic                       out_changed;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;

  adpcm_voice_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_mode    (in_mode),
    .in_value   (in_value),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_sample (out_sample),
    .out_level  (out_level),
    .out_changed(out_changed),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  pin_event_t pending_events [$];
  pcm_t       expected_pcm [$];

  logic              width_q = BIT_WIDTH_RESET;
  logic [PSEL_W-1:0] psel_q  = PSEL_RESET;
  logic [VOL_W-1:0]  vol_q   = VOLUME_RESET;

  logic [CODE_W-1:0] code_q    = '0;
  logic              clk_pin_q = 1'b0;
  logic              rst_pin_q = 1'b0;
  int                level_q   = 0;
  int                step_q    = 0;

  int   mismatches  = 0;
  int   cycle_count = 0;
  int   tx_gap      = 0;
  int   rx_gap      = 0;
  int   rx_hold     = 0;
  bit   quiet       = 1'b0;
  bit   gen_rst     = 1'b0;
  pcm_t got;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void predict_decode();
    int   prev;
    int   nxt;
    int   sv;
    int   mag;
    int   idx;
    int   scaled;
    pcm_t want;
    prev = level_q;
    if (rst_pin_q) begin
      nxt = 0;
      step_q = 0;
    end else begin
      idx = step_q;
      sv = STEP_TABLE[idx];
      mag = sv / 8;
      if (code_q[2]) mag += sv;
      if (code_q[1]) mag += sv / 2;
      if (code_q[0]) mag += sv / 4;
      nxt = code_q[3] ? prev - mag : prev + mag;
      if (nxt > LEVEL_MAX) nxt = LEVEL_MAX;
      else if (nxt < LEVEL_MIN) nxt = LEVEL_MIN;
      idx += ADJUST_TABLE[code_q[2:0]];
      if (idx > STEP_MAX) idx = STEP_MAX;
      else if (idx < 0) idx = 0;
      step_q = idx;
    end
    level_q = nxt;
    scaled = (nxt * 16 * int'(vol_q)) / 100;
    if (scaled > SAMPLE_MAX) scaled = SAMPLE_MAX;
    else if (scaled < -SAMPLE_MIN_MAG) scaled = -SAMPLE_MIN_MAG;
    want.sample  = scaled[SAMPLE_W-1:0];
    want.level   = nxt[LEVEL_W-1:0];
    want.changed = (nxt != prev);
    expected_pcm.push_back(want);
  endfunction

  function automatic void apply_event(pin_event_t ev);
    case (ev.mode)
      MODE_DATA: begin
        code_q = width_q ? ev.value : {ev.value[2:0], 1'b0};
      end
      MODE_RESET_PIN: begin
        rst_pin_q = ev.value[0];
      end
      MODE_CLOCK_PIN: begin
        if (psel_q == PSEL_EXTERNAL && ev.value[0] != clk_pin_q) begin
          clk_pin_q = ev.value[0];
          if (!ev.value[0]) predict_decode();
        end
      end
      default: begin
        if (psel_q != PSEL_EXTERNAL) predict_decode();
      end
    endcase
  endfunction

  // Sender: one event per transfer, held while the queue is full.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) apply_event('{in_mode, in_value});
      if (in_push && in_full) begin
        in_push <= 1'b1;
      end else if (tx_gap > 0) begin
        tx_gap = tx_gap - 1;
        in_push <= 1'b0;
      end else if (pending_events.size() == 0) begin
        in_push <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        tx_gap = $urandom_range(1, 13) - 1;
        in_push <= 1'b0;
      end else begin
        {in_mode, in_value} <= pending_events.pop_front();
        in_push <= 1'b1;
      end
    end
  end

  // Receiver: checks each transfer against the oldest expected result.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_pcm.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: sample %0d level %0d changed %0b",
                     out_sample, out_level, out_changed);
          mismatches++;
        end else begin
          got = expected_pcm.pop_front();
          if (out_sample !== got.sample || out_level !== got.level ||
              out_changed !== got.changed) begin
            if (mismatches < 10)
              $display("mismatch: expected sample %0d level %0d changed %0b, %s %0d %0d %0b",
                       got.sample, got.level, got.changed, "actual",
                       out_sample, out_level, out_changed);
            mismatches++;
          end
        end
      end
      if (rx_hold > 0) begin
        rx_hold = rx_hold - 1;
        out_pop <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap = rx_gap - 1;
        out_pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        rx_gap = $urandom_range(1, 13) - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  task automatic add_event(logic [MODE_W-1:0] m, logic [VALUE_W-1:0] v);
    pending_events.push_back('{m, v});
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_BIT_WIDTH: width_q = data[0];
      CFG_PRESCALER: psel_q = data[PSEL_W-1:0];
      CFG_VOLUME:    vol_q = data;
      default:       ;
    endcase
  endtask

  task automatic configure(logic bw, logic [PSEL_W-1:0] psel, logic [VOL_W-1:0] vol);
    write_reg(CFG_BIT_WIDTH, (8'($urandom) & 8'hFE) | {7'd0, bw});
    write_reg(CFG_PRESCALER, (8'($urandom) & 8'hFC) | {6'd0, psel});
    write_reg(CFG_VOLUME, vol);
  endtask

  task automatic drain();
    while (pending_events.size() != 0 || in_push || expected_pcm.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Mostly complete decode sequences with random codes, the rest noise.
  task automatic fill_random(int count, bit internal);
    int                 base;
    logic [MODE_W-1:0]  m;
    logic [VALUE_W-1:0] v;
    base = pending_events.size();
    while (pending_events.size() - base < count) begin
      if (gen_rst && $urandom_range(0, 1) == 1) begin
        add_event(MODE_RESET_PIN, {3'($urandom), 1'b0});
        gen_rst = 1'b0;
      end
      if ($urandom_range(0, 9) < 8) begin
        add_event(MODE_DATA, 4'($urandom));
        if (internal) begin
          add_event(MODE_TICK, 4'($urandom));
        end else begin
          add_event(MODE_CLOCK_PIN, {3'($urandom), 1'b1});
          add_event(MODE_CLOCK_PIN, {3'($urandom), 1'b0});
        end
      end else begin
        m = 2'($urandom);
        v = 4'($urandom);
        add_event(m, v);
        if (m == MODE_RESET_PIN) gen_rst = v[0];
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (SETTLE) @(negedge clk);

    // Largest positive code until the level clamps high, then the largest negative
    // code; pins without a falling edge; a tick on the external
    // clock; decodes with reset held; the smallest code.
    add_event(MODE_DATA, 4'h7);
    for (int k = 0; k < 6; k++) begin
      add_event(MODE_CLOCK_PIN, k[0] ? 4'hF : 4'h1);
      add_event(MODE_CLOCK_PIN, k[0] ? 4'hE : 4'h0);
    end
    add_event(MODE_DATA, 4'hF);
    add_event(MODE_CLOCK_PIN, 4'h1);
    add_event(MODE_CLOCK_PIN, 4'h0);
    add_event(MODE_CLOCK_PIN, 4'h0);
    add_event(MODE_TICK, 4'hF);
    add_event(MODE_RESET_PIN, 4'hF);
    add_event(MODE_CLOCK_PIN, 4'h1);
    add_event(MODE_CLOCK_PIN, 4'h0);
    add_event(MODE_CLOCK_PIN, 4'h1);
    add_event(MODE_CLOCK_PIN, 4'h0);
    add_event(MODE_RESET_PIN, 4'hE);
    add_event(MODE_DATA, 4'h0);
    add_event(MODE_CLOCK_PIN, 4'h1);
    add_event(MODE_CLOCK_PIN, 4'h0);
    fill_random(90, 1'b0);
    drain();

    configure(1'b0, PSEL_EXTERNAL, 8'd200);
    fill_random(90, 1'b0);
    drain();

    // The receiver holds off while ticks keep arriving, so the input stalls.
    configure(1'b1, PSEL_DIV96, 8'd0);
    rx_hold = 300;
    fill_random(90, 1'b1);
    drain();

    configure(1'b0, PSEL_DIV48, 8'd255);
    fill_random(90, 1'b1);
    drain();

    write_reg(CFG_UNUSED, 8'($urandom));
    configure(1'b1, PSEL_DIV64, 8'd1);
    fill_random(90, 1'b1);
    drain();

    quiet = 1'b1;
    configure(1'b1, PSEL_EXTERNAL, 8'd150);
    fill_random(90, 1'b0);
    drain();

    if (mismatches == 0 && expected_pcm.size() == 0) begin
      $display("adpcm_voice_decoder test passed");
    end else begin
      $display("adpcm_voice_decoder test failed");
    end
    $finish;
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("adpcm_voice_decoder test failed");
    $finish;
  end

endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/core/avd_pkg.sv
rtl/core/avd_front.sv
rtl/core/avd_cmd_fifo.sv
rtl/core/avd_back.sv
rtl/core/adpcm_voice_decoder.sv
tb/tb.sv
